// ===== rtl/fbdr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fbdr_pkg
// Shared types and constants for the frame store with dirty-box tracking.
// ----------------------------------------------------------------------------
package fbdr_pkg;

    localparam int PANEL_WIDTH_DEF  = 160;
    localparam int PANEL_HEIGHT_DEF = 128;

    localparam logic [15:0] WHITE = 16'hFFFF;

    // Opcodes.
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // Status codes.
    localparam logic [1:0] STS_DONE      = 2'd0;
    localparam logic [1:0] STS_UNCHANGED = 2'd1;
    localparam logic [1:0] STS_OOB       = 2'd2;
    localparam logic [1:0] STS_DISABLED  = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_X_OFFSET    = 2'd0;
    localparam logic [1:0] CFG_Y_OFFSET    = 2'd1;
    localparam logic [1:0] CFG_ROTATION    = 2'd2;
    localparam logic [1:0] CFG_DRAW_ENABLE = 2'd3;

    localparam int CFG_DATA_W = 11;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [15:0] x_coord;
        logic signed [15:0] y_coord;
        logic [15:0]        pixel_color;
        logic               force_full_width;
        logic               force_full_height;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] pixel_out;
        logic [7:0]  rect_x;
        logic [7:0]  rect_y;
        logic [8:0]  rect_width;
        logic [8:0]  rect_height;
        logic        rect_empty;
        logic        whole_rows;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_en;
        logic cap_in;
        logic map_en;
        logic addr_en;
        logic rd_en;
        logic finish;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
    } dp_sts_t;

endpackage : fbdr_pkg
`default_nettype wire

// ===== rtl/fbdr_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fbdr_ctrl
// Sequencer: clearing sweep after reset, then a fixed four-step pass per word.
// ----------------------------------------------------------------------------
module fbdr_ctrl
    import fbdr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    output logic         busy,
    output logic         done,
    output dp_cmd_t      cmd,
    input  wire dp_sts_t sts
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAP,
        ST_ADDR,
        ST_READ,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP:    state_next = ST_ADDR;
            ST_ADDR:   state_next = ST_READ;
            ST_READ:   state_next = ST_FINISH;
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != ST_IDLE);
            done_reg  <= (state_reg == ST_FINISH);
        end
    end

    always_comb
    begin
        cmd.clr_en  = (state_reg == ST_CLEAR);
        cmd.cap_in  = (state_reg == ST_IDLE) && start;
        cmd.map_en  = (state_reg == ST_MAP);
        cmd.addr_en = (state_reg == ST_ADDR);
        cmd.rd_en   = (state_reg == ST_READ);
        cmd.finish  = (state_reg == ST_FINISH);
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule : fbdr_ctrl
`default_nettype wire

// ===== rtl/fbdr_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fbdr_dp
// Datapath: configuration registers, coordinate mapping, frame store memory,
// dirty box and result register.
// ----------------------------------------------------------------------------
module fbdr_dp
    import fbdr_pkg::*;
#(
    parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dp_cmd_t               cmd,
    output dp_sts_t                    sts,
    input  wire item_t                 item,
    input  wire logic                  cfg_valid,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output result_t                    result
);

    localparam int DEPTH = PANEL_WIDTH * PANEL_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int MAXD  = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
    localparam int CW    = $clog2(MAXD);
    localparam int DW    = 10;

    localparam logic signed [16:0]   W_S  = 17'(PANEL_WIDTH);
    localparam logic signed [16:0]   H_S  = 17'(PANEL_HEIGHT);
    localparam logic [CW-1:0]        W_M1 = CW'(PANEL_WIDTH - 1);
    localparam logic [CW-1:0]        H_M1 = CW'(PANEL_HEIGHT - 1);
    localparam logic signed [DW-1:0] D_W  = DW'(PANEL_WIDTH);
    localparam logic signed [DW-1:0] D_H  = DW'(PANEL_HEIGHT);
    localparam logic signed [DW-1:0] D_WM = DW'(PANEL_WIDTH - 1);
    localparam logic signed [DW-1:0] D_HM = DW'(PANEL_HEIGHT - 1);
    localparam logic signed [DW-1:0] D_NEG1 = '1;

    // Configuration.
    logic signed [10:0] x_off_reg;
    logic signed [10:0] y_off_reg;
    logic [1:0]         rot_reg;
    logic               draw_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_off_reg   <= '0;
            y_off_reg   <= '0;
            rot_reg     <= '0;
            draw_en_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_X_OFFSET:    x_off_reg   <= cfg_data;
                CFG_Y_OFFSET:    y_off_reg   <= cfg_data;
                CFG_ROTATION:    rot_reg     <= cfg_data[1:0];
                CFG_DRAW_ENABLE: draw_en_reg <= cfg_data[0];
            endcase
        end
    end

    // Captured word.
    item_t in_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.cap_in)
        begin
            in_reg <= item;
        end
    end

    // Offset, bounds check and rotation.
    logic signed [16:0] lx;
    logic signed [16:0] ly;
    logic               inb;
    logic [CW-1:0]      lxc;
    logic [CW-1:0]      lyc;
    logic [CW-1:0]      nx;
    logic [CW-1:0]      ny;
    logic [CW-1:0]      nx_reg;
    logic [CW-1:0]      ny_reg;
    logic               inb_reg;

    always_comb
    begin
        lx  = 17'(in_reg.x_coord) + 17'(x_off_reg);
        ly  = 17'(in_reg.y_coord) + 17'(y_off_reg);
        inb = !lx[16] && !ly[16] &&
              (rot_reg[0] ? (lx < H_S && ly < W_S) : (lx < W_S && ly < H_S));
        lxc = lx[CW-1:0];
        lyc = ly[CW-1:0];
        unique case (rot_reg)
            2'd1:
            begin
                nx = W_M1 - lyc;
                ny = lxc;
            end
            2'd2:
            begin
                nx = W_M1 - lxc;
                ny = H_M1 - lyc;
            end
            2'd3:
            begin
                nx = lyc;
                ny = H_M1 - lxc;
            end
            default:
            begin
                nx = lxc;
                ny = lyc;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.map_en)
        begin
            nx_reg  <= nx;
            ny_reg  <= ny;
            inb_reg <= inb;
        end
    end

    // Store address.
    logic [AW-1:0] addr_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.addr_en)
        begin
            addr_reg <= AW'(ny_reg) * AW'(PANEL_WIDTH) + AW'(nx_reg);
        end
    end

    // Clearing sweep counter.
    logic [AW-1:0] clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_en)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    assign sts.clr_last = (clr_cnt_reg == AW'(DEPTH - 1));

    // Frame store.
    logic [15:0]   mem [DEPTH];
    logic [15:0]   rd_data_reg;
    logic          we;
    logic [AW-1:0] waddr;
    logic [15:0]   wdata;
    logic          pix_write;

    assign pix_write = cmd.finish && (in_reg.opcode == OP_WRITE) && draw_en_reg &&
                       inb_reg && (rd_data_reg != in_reg.pixel_color);
    assign we    = cmd.clr_en || pix_write;
    assign waddr = cmd.clr_en ? clr_cnt_reg : addr_reg;
    assign wdata = cmd.clr_en ? WHITE : in_reg.pixel_color;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    // Dirty box and result.
    logic signed [DW-1:0] left_reg, right_reg, top_reg, bottom_reg;
    logic signed [DW-1:0] left_next, right_next, top_next, bottom_next;
    logic signed [DW-1:0] l1, r1, t1, b1;
    logic signed [DW-1:0] nx_s, ny_s;
    logic signed [DW-1:0] box_w, box_h;
    logic                 box_empty;
    result_t              res_reg;
    result_t              res_next;

    always_comb
    begin
        nx_s      = DW'(nx_reg);
        ny_s      = DW'(ny_reg);
        l1        = in_reg.force_full_width  ? '0   : left_reg;
        r1        = in_reg.force_full_width  ? D_WM : right_reg;
        t1        = in_reg.force_full_height ? '0   : top_reg;
        b1        = in_reg.force_full_height ? D_HM : bottom_reg;
        box_empty = (r1 < l1) || (b1 < t1);
        box_w     = r1 - l1 + DW'(1);
        box_h     = b1 - t1 + DW'(1);

        left_next   = left_reg;
        right_next  = right_reg;
        top_next    = top_reg;
        bottom_next = bottom_reg;
        res_next    = '0;

        case (in_reg.opcode)
            OP_WRITE:
            begin
                if (!draw_en_reg)
                begin
                    res_next.status = STS_DISABLED;
                end
                else if (!inb_reg)
                begin
                    res_next.status = STS_OOB;
                end
                else if (rd_data_reg == in_reg.pixel_color)
                begin
                    res_next.status = STS_UNCHANGED;
                end
                else
                begin
                    if (nx_s < left_reg)   left_next   = nx_s;
                    if (nx_s > right_reg)  right_next  = nx_s;
                    if (ny_s < top_reg)    top_next    = ny_s;
                    if (ny_s > bottom_reg) bottom_next = ny_s;
                end
            end
            OP_READ:
            begin
                if (inb_reg)
                begin
                    res_next.pixel_out = rd_data_reg;
                end
                else
                begin
                    res_next.status = STS_OOB;
                end
            end
            OP_FLUSH:
            begin
                if (box_empty)
                begin
                    // Forced bounds stay in the box when the other axis is empty.
                    res_next.rect_empty = 1'b1;
                    left_next   = l1;
                    right_next  = r1;
                    top_next    = t1;
                    bottom_next = b1;
                end
                else
                begin
                    res_next.rect_x      = l1[7:0];
                    res_next.rect_y      = t1[7:0];
                    res_next.rect_width  = box_w[8:0];
                    res_next.rect_height = box_h[8:0];
                    res_next.whole_rows  = (box_w == D_W);
                    left_next   = D_W;
                    right_next  = D_NEG1;
                    top_next    = D_H;
                    bottom_next = D_NEG1;
                end
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= D_W;
            right_reg  <= D_NEG1;
            top_reg    <= D_H;
            bottom_reg <= D_NEG1;
        end
        else if (cmd.finish)
        begin
            left_reg   <= left_next;
            right_reg  <= right_next;
            top_reg    <= top_next;
            bottom_reg <= bottom_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            res_reg <= res_next;
        end
    end

    assign result = res_reg;

endmodule : fbdr_dp
`default_nettype wire

// ===== rtl/framebuffer_dirty_rect_tracker_top.sv =====
`default_nettype none
// Flow: a word accepted on start passes the map, address multiply, store read
// and finish steps, then gives its result on the done strobe.
// Words do not overlap; start is taken again from the strobe cycle on.
// Reset: after rst_n rises, a sweep writes white to every store entry, one per
// cycle (PANEL_WIDTH * PANEL_HEIGHT entries, 20480 by default) with busy high.
// Results cannot be stalled; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
// framebuffer_dirty_rect_tracker_top
// Frame store with rotation mapping and dirty-box tracking.
// ----------------------------------------------------------------------------
module framebuffer_dirty_rect_tracker_top
    import fbdr_pkg::*;
#(
    parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire item_t                 item,
    output logic                       done,
    output result_t                    result,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    fbdr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .sts   (sts)
    );

    fbdr_dp #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

endmodule : framebuffer_dirty_rect_tracker_top
`default_nettype wire

// ===== rtl/fbdr_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fbdr_checker
// Port-level checks on the command handshake and result words.
// ----------------------------------------------------------------------------
module fbdr_checker
    import fbdr_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    start,
    input wire logic    busy,
    input wire logic    done,
    input wire result_t result
);

    // An accepted word keeps the block busy until its result is out.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting a word");

    // Each word gives a single one-cycle strobe.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe longer than one cycle");

    // The result appears only once the block is ready for the next word.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done strobe while busy");

    // An empty flush reports no box.
    a_empty_box: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.rect_empty) |->
            (result.rect_width == 9'd0 && result.rect_height == 9'd0 &&
             !result.whole_rows))
        else $error("empty flush reported a box");

    // Only a flush reports a box, and a flush always completes.
    a_box_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != STS_DONE) |->
            (result.rect_width == 9'd0 && !result.rect_empty))
        else $error("box fields set on a non-flush word");

endmodule : fbdr_checker

bind framebuffer_dirty_rect_tracker_top fbdr_checker u_fbdr_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
`default_nettype wire
